/* design/hpid_pkg.sv */
`timescale 1ns / 1ps

package hpid_pkg;

    // field widths
    localparam int HEAD_W  = 15;
    localparam int DT_W    = 16;
    localparam int SP_W    = 16;
    localparam int GAIN_W  = 24;
    localparam int SERVO_W = 14;

    // apb register map
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KP       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KI       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_KD       = 2'd3;

    localparam logic [SP_W-1:0]   RST_SETPOINT = 16'd5760;
    localparam logic [GAIN_W-1:0] RST_KP       = 24'd65536;
    localparam logic [GAIN_W-1:0] RST_KI       = 24'd655;
    localparam logic [GAIN_W-1:0] RST_KD       = 24'd6554;

    // fixed point format
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int LIMIT_DEG       = 90;
    localparam int MS_PER_S        = 1000;

    // internal widths
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int EMAG_W    = 16;
    localparam int DMAG_W    = 17;
    localparam int MUL_STEPS = 17;
    localparam int PROD_W    = GAIN_W + MUL_STEPS;
    localparam int INUM_W    = PROD_W - 1 + MUL_STEPS;
    localparam int DNUM_W    = PROD_W + MUL_STEPS;
    localparam int DIV_STEPS = 56;
    localparam int IREM_W    = 10;
    localparam int DREM_W    = DT_W;
    localparam int IQ_W      = 47;
    localparam int DQ_W      = 51;
    localparam int ISUM_W    = 48;
    localparam int ACC_W     = 54;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam longint LIMIT_VAL =
        longint'(LIMIT_DEG) << (ANGLE_FRAC_BITS + GAIN_FRAC_BITS);
    localparam logic [ACC_W-1:0] LIMIT_POS = ACC_W'(LIMIT_VAL);
    localparam logic [ACC_W-1:0] LIMIT_NEG = ACC_W'(-LIMIT_VAL);
    localparam logic [SERVO_W-1:0] SERVO_MAX =
        SERVO_W'((2 * LIMIT_VAL) >> GAIN_FRAC_BITS);

    localparam logic [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
    localparam logic [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_FIN1 = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_FIN3 = 7'b1000000
    } t_state;

endpackage

/* design/heading_pid_servo_controller_unit.sv */
`timescale 1ns / 1ps

// heading pid servo controller
// input channel (i_in_valid / o_in_ready) carries one pid update: measured heading
// and elapsed milliseconds. output channel (o_out_valid / i_out_ready) returns the
// servo angle and a clamp flag, one result per input transfer, in order.
// gains and setpoint sit behind an apb port (0x0 setpoint, 0x4 kp, 0x8 ki, 0xc kd).
// the user must write them only while no update is in flight; the block does not enforce it.
// each update runs bit-serially through one sequencer: two shift-add multiply passes
// (p, i and d products side by side), a restoring divide (integral by 1000 and
// derivative by dt in parallel), then the final steps FIN1, FIN2 and FIN3, which
// saturate the integral, sum the terms and clamp. the sequencer returns to idle
// once the result is loaded, and only then is the next input taken.
// a stalled receiver holds the result in the output register; the next update is
// still accepted and computed, and waits in its last step until the register frees.
// reset loads the default gains and setpoint, clears the integral and the previous
// error and empties the output register.

module heading_pid_servo_controller_unit
    import hpid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [HEAD_W-1:0]  i_measured_heading,
    input  logic [DT_W-1:0]           i_elapsed_ms,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [SERVO_W-1:0]        o_servo_angle,
    output logic                      o_output_clamped
);

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;

    logic signed [SP_W-1:0] r_setpoint;
    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;

    logic [ISUM_W-1:0] r_integ;
    logic signed [ERR_W-1:0] r_last_err;

    logic r_e_neg;
    logic r_diff_neg;
    logic r_dt_zero;
    logic [EMAG_W-1:0] r_e_mag;
    logic [DT_W-1:0] r_dt;

    logic [PROD_W-1:0] r_p_prod;
    logic [PROD_W-1:0] r_i_prod;
    logic [PROD_W-1:0] r_d_prod;
    logic [INUM_W-1:0] r_i_num;
    logic [DNUM_W-1:0] r_d_num;
    logic [IREM_W-1:0] r_i_rem;
    logic [DREM_W-1:0] r_d_rem;
    logic [ACC_W-1:0] r_acc;

    logic r_out_valid;
    logic [SERVO_W-1:0] r_servo;
    logic r_clamped;

    logic cfg_wr;
    logic w_load;

    logic signed [ERR_W-1:0] w_err;
    logic signed [DIFF_W-1:0] w_diff;
    logic [EMAG_W-1:0] w_emag;
    logic [DMAG_W-1:0] w_dmag;

    logic [GAIN_W:0] n_p_sum;
    logic [GAIN_W:0] n_i_sum;
    logic [GAIN_W:0] n_d_sum;
    logic [PROD_W-1:0] n_p_prod;
    logic [PROD_W-1:0] n_i_prod;
    logic [PROD_W-1:0] n_d_prod;

    logic [PROD_W-1:0] n_im_sum;
    logic [PROD_W:0] n_dm_sum;
    logic [INUM_W-1:0] n_i_mul;
    logic [DNUM_W-1:0] n_d_mul;

    logic [IREM_W:0] n_i_trial;
    logic [DREM_W:0] n_d_trial;
    logic n_i_qbit;
    logic n_d_qbit;
    logic [IREM_W-1:0] n_i_rem;
    logic [DREM_W-1:0] n_d_rem;
    logic [INUM_W-1:0] n_i_div;
    logic [DNUM_W-1:0] n_d_div;

    logic [ISUM_W-1:0] n_i_mag;
    logic [ISUM_W-1:0] n_inc;
    logic [ISUM_W:0] n_isum;
    logic [ISUM_W-1:0] n_integ;
    logic [ACC_W-1:0] n_p_mag;
    logic [ACC_W-1:0] n_d_mag;
    logic [ACC_W-1:0] n_p_term;
    logic [ACC_W-1:0] n_d_term;
    logic [ACC_W-1:0] n_acc_pd;
    logic [ACC_W-1:0] n_acc_all;
    logic [ACC_W-1:0] n_sum;
    logic [ACC_W-1:0] n_span;
    logic n_clamped;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_SETPOINT: prdata = {{(PDATA_W-SP_W){1'b0}}, r_setpoint};
            REG_KP:       prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_kp};
            REG_KI:       prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_ki};
            REG_KD:       prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_kd};
            default:      prdata = '0;
        endcase
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_servo_angle    = r_servo;
    assign o_output_clamped = r_clamped;

    assign w_load = (r_state == S_FIN3) && (!r_out_valid || i_out_ready);

    // error and error change, in sign and magnitude
    always_comb begin
        w_err  = ERR_W'(i_measured_heading) - ERR_W'(r_setpoint);
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_last_err);
        w_emag = w_err[ERR_W-1] ? EMAG_W'(-w_err) : EMAG_W'(w_err);
        w_dmag = w_diff[DIFF_W-1] ? DMAG_W'(-w_diff) : DMAG_W'(w_diff);
    end

    // shift-add multiply steps, multiplier in the low bits, lsb first
    always_comb begin
        n_p_sum  = {1'b0, r_p_prod[PROD_W-1:MUL_STEPS]}
                 + (r_p_prod[0] ? {1'b0, r_kp} : '0);
        n_i_sum  = {1'b0, r_i_prod[PROD_W-1:MUL_STEPS]}
                 + (r_i_prod[0] ? {1'b0, r_ki} : '0);
        n_d_sum  = {1'b0, r_d_prod[PROD_W-1:MUL_STEPS]}
                 + (r_d_prod[0] ? {1'b0, r_kd} : '0);
        n_p_prod = {n_p_sum, r_p_prod[MUL_STEPS-1:1]};
        n_i_prod = {n_i_sum, r_i_prod[MUL_STEPS-1:1]};
        n_d_prod = {n_d_sum, r_d_prod[MUL_STEPS-1:1]};

        n_im_sum = {1'b0, r_i_num[INUM_W-1:MUL_STEPS]}
                 + (r_i_num[0] ? {1'b0, r_i_prod[PROD_W-2:0]} : '0);
        n_dm_sum = {1'b0, r_d_num[DNUM_W-1:MUL_STEPS]}
                 + (r_d_num[0] ? {1'b0, r_d_prod} : '0);
        n_i_mul  = {n_im_sum, r_i_num[MUL_STEPS-1:1]};
        n_d_mul  = {n_dm_sum, r_d_num[MUL_STEPS-1:1]};
    end

    // restoring divide steps, dividend in the low DIV_STEPS bits becomes the quotient
    always_comb begin
        n_i_trial = {r_i_rem, r_i_num[DIV_STEPS-1]};
        n_i_qbit  = (n_i_trial >= (IREM_W+1)'(MS_PER_S));
        n_i_rem   = n_i_qbit ? IREM_W'(n_i_trial - (IREM_W+1)'(MS_PER_S))
                             : n_i_trial[IREM_W-1:0];
        n_i_div   = {r_i_num[INUM_W-2:0], n_i_qbit};

        n_d_trial = {r_d_rem, r_d_num[DIV_STEPS-1]};
        n_d_qbit  = (n_d_trial >= {1'b0, r_dt});
        n_d_rem   = n_d_qbit ? DREM_W'(n_d_trial - {1'b0, r_dt})
                             : n_d_trial[DREM_W-1:0];
        n_d_div   = {r_d_num[DNUM_W-2:0], n_d_qbit};
    end

    // integral saturation, term sums and output clamp
    always_comb begin
        n_i_mag = ISUM_W'(r_i_num[IQ_W-1:0]);
        n_inc   = r_e_neg ? -n_i_mag : n_i_mag;
        n_isum  = {r_integ[ISUM_W-1], r_integ} + {n_inc[ISUM_W-1], n_inc};
        if (n_isum[ISUM_W] != n_isum[ISUM_W-1]) begin
            n_integ = n_isum[ISUM_W] ? ISUM_MIN : ISUM_MAX;
        end else begin
            n_integ = n_isum[ISUM_W-1:0];
        end

        n_p_mag  = ACC_W'(r_p_prod[PROD_W-2:0]);
        n_d_mag  = ACC_W'(r_d_num[DQ_W-1:0]);
        n_p_term = r_e_neg ? -n_p_mag : n_p_mag;
        n_d_term = r_dt_zero ? '0 : (r_diff_neg ? -n_d_mag : n_d_mag);
        n_acc_pd = n_p_term + n_d_term;
        n_acc_all = r_acc + {{(ACC_W-ISUM_W){r_integ[ISUM_W-1]}}, r_integ};

        n_clamped = 1'b0;
        n_sum     = r_acc;
        if ($signed(r_acc) < $signed(LIMIT_NEG)) begin
            n_sum     = LIMIT_NEG;
            n_clamped = 1'b1;
        end
        if ($signed(r_acc) > $signed(LIMIT_POS)) begin
            n_sum     = LIMIT_POS;
            n_clamped = 1'b1;
        end
        n_span = LIMIT_POS - n_sum;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_setpoint  <= RST_SETPOINT;
            r_kp        <= RST_KP;
            r_ki        <= RST_KI;
            r_kd        <= RST_KD;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[PADDR_W-1:2])
                    REG_SETPOINT: r_setpoint <= pwdata[SP_W-1:0];
                    REG_KP:       r_kp       <= pwdata[GAIN_W-1:0];
                    REG_KI:       r_ki       <= pwdata[GAIN_W-1:0];
                    REG_KD:       r_kd       <= pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last_err <= w_err;
                        r_cnt      <= CNT_W'(MUL_STEPS - 1);
                        r_state    <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(MUL_STEPS - 1);
                        r_state <= S_MUL2;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MUL2: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN1: begin
                    r_integ <= n_integ;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_e_neg    <= w_err[ERR_W-1];
                    r_diff_neg <= w_diff[DIFF_W-1];
                    r_e_mag    <= w_emag;
                    r_dt       <= i_elapsed_ms;
                    r_dt_zero  <= (i_elapsed_ms == '0);
                    r_p_prod   <= PROD_W'(w_emag);
                    r_i_prod   <= PROD_W'(i_elapsed_ms);
                    r_d_prod   <= PROD_W'(w_dmag);
                end
            end
            S_MUL1: begin
                r_p_prod <= n_p_prod;
                r_i_prod <= n_i_prod;
                r_d_prod <= n_d_prod;
                if (r_cnt == '0) begin
                    r_i_num <= INUM_W'(r_e_mag);
                    r_d_num <= DNUM_W'(MS_PER_S);
                end
            end
            S_MUL2: begin
                r_i_num <= n_i_mul;
                r_d_num <= n_d_mul;
                if (r_cnt == '0) begin
                    r_i_rem <= '0;
                    r_d_rem <= '0;
                end
            end
            S_DIV: begin
                r_i_num <= n_i_div;
                r_d_num <= n_d_div;
                r_i_rem <= n_i_rem;
                r_d_rem <= n_d_rem;
            end
            S_FIN1: begin
                r_acc <= n_acc_pd;
            end
            S_FIN2: begin
                r_acc <= n_acc_all;
            end
            S_FIN3: begin
                if (w_load) begin
                    r_servo   <= n_span[GAIN_FRAC_BITS +: SERVO_W];
                    r_clamped <= n_clamped;
                end
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
            (r_state == S_MUL1 && r_cnt == CNT_W'(MUL_STEPS - 1)))
        else $error("update did not start the multiply pass");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished update not presented");

    a_irem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_i_rem < IREM_W'(MS_PER_S)))
        else $error("integral divide remainder out of range");

    a_drem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_dt_zero) |-> (r_d_rem < r_dt))
        else $error("derivative divide remainder out of range");

    a_clamp_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clamped) |-> (r_servo == '0 || r_servo == SERVO_MAX))
        else $error("clamped result not at a servo end stop");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb
    import hpid_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam longint ISAT_HI = (longint'(1) <<< 47) - 1;
    localparam longint ISAT_LO = -(longint'(1) <<< 47);
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef struct packed {
        logic [SERVO_W-1:0] angle;
        logic               clamped;
    } t_servo_cmd;

    class pid_servo_model;
        logic signed [SP_W-1:0] setpoint;
        logic [GAIN_W-1:0]      kp, ki, kd;
        longint                 integ, prev_err;
        t_servo_cmd             pending_cmds[$];
        int                     errors;

        function new();
            setpoint = RST_SETPOINT;
            kp = RST_KP;
            ki = RST_KI;
            kd = RST_KD;
            integ = 0;
            prev_err = 0;
            errors = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_SETPOINT: setpoint = value[SP_W-1:0];
                REG_KP:       kp = value[GAIN_W-1:0];
                REG_KI:       ki = value[GAIN_W-1:0];
                REG_KD:       kd = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // magnitude times factor over den, truncated toward zero
        function longint scale_div(longint num, longint unsigned factor,
                                   longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : num;
            q = (mag * factor) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void take_update(logic signed [HEAD_W-1:0] heading, logic [DT_W-1:0] dt);
            longint     err, p_term, d_term, total;
            t_servo_cmd cmd;
            err = longint'(heading) - longint'(setpoint);
            p_term = err * longint'(kp);
            integ += scale_div(err, longint'(ki) * longint'(dt), MS_PER_S);
            if (integ > ISAT_HI) integ = ISAT_HI;
            if (integ < ISAT_LO) integ = ISAT_LO;
            if (dt == 0)
                d_term = 0;
            else
                d_term = scale_div(err - prev_err, longint'(kd) * MS_PER_S, longint'(dt));
            total = p_term + integ + d_term;
            cmd.clamped = 1'b0;
            if (total < -LIMIT_VAL) begin
                total = -LIMIT_VAL;
                cmd.clamped = 1'b1;
            end
            if (total > LIMIT_VAL) begin
                total = LIMIT_VAL;
                cmd.clamped = 1'b1;
            end
            prev_err = err;
            cmd.angle = SERVO_W'((LIMIT_VAL - total) >>> GAIN_FRAC_BITS);
            pending_cmds.push_back(cmd);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_cmd(logic [SERVO_W-1:0] angle, logic clamped);
            t_servo_cmd want;
            if (pending_cmds.size() == 0) begin
                report("result with no update pending", angle, -1);
            end else begin
                want = pending_cmds.pop_front();
                if (angle !== want.angle) report("servo_angle", angle, want.angle);
                if (clamped !== want.clamped) report("output_clamped", clamped, want.clamped);
            end
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [HEAD_W-1:0] i_measured_heading = '0;
    logic [DT_W-1:0]          i_elapsed_ms = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [SERVO_W-1:0]       o_servo_angle;
    logic                     o_output_clamped;

    pid_servo_model model;
    bit             calm = 1'b0;
    int             cycles = 0;
    int             stall_left = 0;

    heading_pid_servo_controller_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_measured_heading (i_measured_heading),
        .i_elapsed_ms       (i_elapsed_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_servo_angle      (o_servo_angle),
        .o_output_clamped   (o_output_clamped)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check every transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            model.check_cmd(o_servo_angle, o_output_clamped);
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(399) == 0) begin
            // occasional long stall so a finished update waits behind the held result
            stall_left = $urandom_range(200, 40);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    task apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        model.set_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high after a transfer only when the next update follows at once
    task send_update(logic signed [HEAD_W-1:0] heading, logic [DT_W-1:0] dt);
        if (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < 27);
        end
        i_in_valid <= 1'b1;
        i_measured_heading <= heading;
        i_elapsed_ms <= dt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model.take_update(heading, dt);
    endtask

    task drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_gains(logic signed [SP_W-1:0] sp, logic [GAIN_W-1:0] kp,
                     logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(REG_SETPOINT, {junk[15:0], sp});
        apb_write(REG_KP, {junk[23:16], kp});
        apb_write(REG_KI, {junk[31:24], ki});
        apb_write(REG_KD, {junk[7:0], kd});
    endtask

    // walk a large integral back near zero with the largest integral gain
    task settle_integral();
        longint            want;
        logic [DT_W-1:0]   dt;
        write_gains('0, '0, GAIN_MAX, '0);
        while (model.integ > (longint'(1) <<< 30) || model.integ < -(longint'(1) <<< 30)) begin
            dt = (model.integ > (longint'(1) <<< 40) || model.integ < -(longint'(1) <<< 40))
                 ? 16'd65535 : 16'd1000;
            want = -(model.integ * MS_PER_S) / (longint'(GAIN_MAX) * longint'(dt));
            if (want > 16383) want = 16383;
            if (want < -16384) want = -16384;
            send_update(HEAD_W'(want), dt);
        end
        drain_results();
    endtask

    task start_phase(logic signed [SP_W-1:0] sp, logic [GAIN_W-1:0] kp,
                     logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
        drain_results();
        if (model.integ > (longint'(1) <<< 30) || model.integ < -(longint'(1) <<< 30))
            settle_integral();
        write_gains(sp, kp, ki, kd);
    endtask

    function logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return GAIN_MAX;
        return GAIN_W'($urandom_range(32'hFFFFFF) >> $urandom_range(23));
    endfunction

    function logic signed [SP_W-1:0] rand_setpoint();
        if ($urandom_range(99) < 70)
            return SP_W'(int'($urandom_range(46080)) - 23040);
        return SP_W'($urandom_range(65535));
    endfunction

    function logic signed [HEAD_W-1:0] rand_heading();
        int r;
        int h;
        r = $urandom_range(99);
        if (r < 50)
            h = int'(model.setpoint) + int'($urandom_range(400)) - 200;
        else if (r < 85)
            h = int'($urandom_range(23040)) - 11520;
        else
            h = int'($urandom_range(32767)) - 16384;
        if (h > 16383) h = 16383;
        if (h < -16384) h = -16384;
        return HEAD_W'(h);
    endfunction

    function logic [DT_W-1:0] rand_dt();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 70) return DT_W'($urandom_range(50, 1));
        if (r < 85) return DT_W'($urandom_range(2000, 1));
        return DT_W'($urandom_range(65535));
    endfunction

    initial begin
        int ph;
        int n;
        model = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // output rounding with unit proportional gain
        start_phase('0, 24'd1, '0, '0);
        send_update(15'sd1, 16'd5);
        send_update(-15'sd1, 16'd5);
        send_update(15'sd0, 16'd0);
        send_update(15'sd11520, 16'd5);
        send_update(-15'sd11520, 16'd5);

        // reset gains, heading and time extremes
        start_phase(RST_SETPOINT, RST_KP, RST_KI, RST_KD);
        send_update(15'sd11520, 16'd10);
        send_update(-15'sd11520, 16'd0);
        send_update(15'sd16383, 16'd65535);
        send_update(-15'sd16384, 16'd1);
        send_update(15'sd0, 16'd1000);

        // integral saturation, high side then low side
        start_phase(-16'sd32768, '0, GAIN_MAX, '0);
        repeat (3) send_update(15'sd16383, 16'd65535);
        start_phase(16'sd32767, '0, GAIN_MAX, '0);
        repeat (6) send_update(-15'sd16384, 16'd65535);

        // full proportional and derivative gains, zero elapsed time
        start_phase('0, GAIN_MAX, '0, GAIN_MAX);
        send_update(15'sd16383, 16'd1);
        send_update(-15'sd16384, 16'd1);
        send_update(15'sd0, 16'd0);
        send_update(15'sd5, 16'd65535);

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                1: start_phase(16'sd23040, GAIN_MAX, GAIN_MAX, GAIN_MAX);
                2: start_phase(-16'sd23040, '0, '0, '0);
                default: start_phase(rand_setpoint(), rand_gain(), rand_gain(), rand_gain());
            endcase
            calm = (ph == 3);
            for (n = 0; n < 150; n++) begin
                if ($urandom_range(49) == 0)
                    drain_results();
                send_update(rand_heading(), rand_dt());
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (model.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
